### sv/mwh_pkg.sv
package mwh_pkg;

    // Mixing and finalization constants of MurmurHash3 x86_32
    localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2   = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_C1   = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2   = 32'hc2b2ae35;

    // Byte count of a full word
    localparam logic [2:0] FULL_COUNT = 3'd4;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic [31:0] word;   // bytes above the count already cleared
        logic [2:0]  count;  // clamped to 0..4
        logic        full;   // four valid bytes
        logic        ends;   // closes the message
    } t_item;

    // Back status seen by the top level
    typedef struct packed {
        logic pop;        // back takes the queue head this cycle
        logic finishing;  // back is in the output step, loading the output register once it is free
    } t_back_status;

endpackage

### sv/mwh_front.sv
module mwh_front (
    input  logic [31:0]    i_data_word,
    input  logic [2:0]     i_valid_bytes,
    input  logic           i_last_word,
    output mwh_pkg::t_item o_item
);

    logic [2:0]  count;
    logic [31:0] mask;

    // Clamp the count and pick the byte mask
    always_comb begin
        case (i_valid_bytes)
            3'd0: begin
                count = 3'd0;
                mask  = 32'h0000_0000;
            end
            3'd1: begin
                count = 3'd1;
                mask  = 32'h0000_00ff;
            end
            3'd2: begin
                count = 3'd2;
                mask  = 32'h0000_ffff;
            end
            3'd3: begin
                count = 3'd3;
                mask  = 32'h00ff_ffff;
            end
            default: begin
                count = mwh_pkg::FULL_COUNT;
                mask  = 32'hffff_ffff;
            end
        endcase
    end

    // Classify: a short word or the last mark ends the message
    always_comb begin
        o_item.word  = i_data_word & mask;
        o_item.count = count;
        o_item.full  = (count == mwh_pkg::FULL_COUNT);
        o_item.ends  = (count != mwh_pkg::FULL_COUNT) || i_last_word;
    end

endmodule

### sv/mwh_queue.sv
module mwh_queue #(
    parameter int DEPTH = mwh_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mwh_pkg::t_item i_push_item,
    input  logic           i_pop,
    output mwh_pkg::t_item o_head,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwh_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### sv/mwh_back.sv
module mwh_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_seed,
    input  mwh_pkg::t_item        i_head,
    input  logic                  i_empty,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [31:0]           o_hash_value,
    output mwh_pkg::t_back_status o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX2,
        S_FOLD,
        S_FIN1,
        S_FIN2,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_k;
    logic [2:0]  r_count;
    logic        r_full;
    logic        r_ends;
    logic [31:0] r_hash;
    logic [31:0] r_len;
    logic        r_in_msg;
    logic [31:0] r_f;
    logic        r_out_valid;
    logic [31:0] r_out;

    logic [31:0] base_hash;
    logic [31:0] base_len;
    logic [31:0] xor_hash;
    logic [31:0] rot_hash;
    logic [31:0] fold_hash;
    logic [31:0] fold_len;
    logic [31:0] fin_in;
    logic        pop;
    logic        out_free;

    assign pop      = (r_state == S_IDLE) && !i_empty;
    assign out_free = !r_out_valid || !i_out_stall;

    // Fold the mixed word into the running hash and length
    always_comb begin
        base_hash = r_in_msg ? r_hash : i_seed;
        base_len  = r_in_msg ? r_len : 32'd0;
        xor_hash  = base_hash ^ r_k;
        rot_hash  = {xor_hash[18:0], xor_hash[31:19]};
        fold_hash = r_full ? (rot_hash * 32'd5 + mwh_pkg::FOLD_ADD) : xor_hash;
        fold_len  = base_len + {29'd0, r_count};
        fin_in    = fold_hash ^ fold_len;
    end

    // Sequence one item through mix and fold, and through finalize if it ends its message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise output valid out of the finishing step, drop it once transferred
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_k     <= i_head.word * mwh_pkg::MIX_C1;
                        r_count <= i_head.count;
                        r_full  <= i_head.full;
                        r_ends  <= i_head.ends;
                        r_state <= S_MIX2;
                    end
                end
                S_MIX2: begin
                    r_k     <= {r_k[16:0], r_k[31:17]} * mwh_pkg::MIX_C2;
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_hash <= fold_hash;
                    r_len  <= fold_len;
                    r_f    <= fin_in ^ {16'd0, fin_in[31:16]};
                    if (r_ends) begin
                        r_in_msg <= 1'b0;
                        r_state  <= S_FIN1;
                    end else begin
                        r_in_msg <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_FIN1: begin
                    r_f     <= r_f * mwh_pkg::FIN_C1;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_f     <= (r_f ^ {13'd0, r_f[31:13]}) * mwh_pkg::FIN_C2;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out   <= r_f ^ {16'd0, r_f[31:16]};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hash_value       = r_out;
    assign o_status.pop       = pop;
    assign o_status.finishing = (r_state == S_OUT);

endmodule

### sv/murmur3_word_hasher.sv
// A word that ends its message shows its hash after the back states S_MIX2, S_FOLD,
// S_FIN1, S_FIN2 and S_OUT, when the queue and output are free. The back sequencer steps
// one queued item at a time through mix and fold, and through finalize for an item that
// ends its message, taking no new item until done with the last. The input queue absorbs bursts.
// Reset (synchronous, active low) clears the seed to zero, empties the queue, closes any
// open message and drops output valid.
module murmur3_word_hasher #(
    parameter int QUEUE_DEPTH = mwh_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    logic [31:0]           r_seed;
    mwh_pkg::t_item        front_item;
    mwh_pkg::t_item        q_head;
    logic                  q_empty;
    logic                  q_full;
    logic                  q_push;
    mwh_pkg::t_back_status back_st;

    // Hold the seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
        end else if (i_seed_we) begin
            r_seed <= i_seed_data;
        end
    end

    assign o_in_stall = q_full;
    assign q_push     = i_in_valid && !q_full;

    mwh_front u_front (
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_item        (front_item)
    );

    mwh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_item (front_item),
        .i_pop       (back_st.pop),
        .o_head      (q_head),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    mwh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_head       (q_head),
        .i_empty      (q_empty),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_hash_value (o_hash_value),
        .o_status     (back_st)
    );

    // An empty queue never stalls the input
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !o_in_stall)
        else $error("input stalled with empty queue");

    // The back takes only from a queue that holds an item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_st.pop |-> !q_empty)
        else $error("pop from empty queue");

    // A new result appears only out of the finishing step
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(back_st.finishing))
        else $error("output valid raised outside the finishing step");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int EXP_DEPTH = 4096;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_seed_we = 1'b0;
    logic [31:0] i_seed_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_data_word = '0;
    logic [2:0]  i_valid_bytes = '0;
    logic        i_last_word = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_hash_value;

    // Predictor state, mirrors the hasher
    logic [31:0] seed_copy = '0;
    logic [31:0] acc_hash = '0;
    logic [31:0] acc_length = '0;
    logic        msg_open = 1'b0;
    logic [31:0] expected_mem [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          tx_count = 0;

    int          failures = 0;
    int unsigned cycle_count = 0;
    bit          quiet = 1'b0;
    int          rx_left = 0;

    murmur3_word_hasher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_data   (i_seed_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hash_value  (o_hash_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("murmur3_word_hasher: mismatch");
            $finish;
        end
    end

    // Stall the result side in random bursts, free stretches in between
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            rx_left <= $urandom_range(0, 10);
        end else begin
            i_out_stall <= 1'b0;
            rx_left <= $urandom_range(0, 29);
        end
    end

    // Compare each result transfer with the oldest expected hash
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                $error("hash_value: expected none, actual %h", o_hash_value);
                failures++;
            end else begin
                if (o_hash_value !== expected_mem[exp_rd % EXP_DEPTH]) begin
                    $error("hash_value: expected %h, actual %h",
                           expected_mem[exp_rd % EXP_DEPTH], o_hash_value);
                    failures++;
                end
                exp_rd++;
            end
        end
    end

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * mwh_pkg::MIX_C1;
        t = rotl32(t, 15);
        return t * mwh_pkg::MIX_C2;
    endfunction

    // Advance the predicted hash by one accepted word
    task automatic absorb_word(input logic [31:0] word, input logic [2:0] count,
                               input logic last);
        logic [2:0]  n;
        logic [31:0] mask;
        logic [31:0] h;
        n = (count > mwh_pkg::FULL_COUNT) ? mwh_pkg::FULL_COUNT : count;
        if (!msg_open) begin
            acc_hash = seed_copy;
            acc_length = '0;
            msg_open = 1'b1;
        end
        if (n == mwh_pkg::FULL_COUNT) begin
            acc_hash = acc_hash ^ scramble_word(word);
            acc_hash = rotl32(acc_hash, 13) * 32'd5 + mwh_pkg::FOLD_ADD;
        end else if (n != 0) begin
            mask = (32'd1 << (8 * n)) - 32'd1;
            acc_hash = acc_hash ^ scramble_word(word & mask);
        end
        acc_length = acc_length + {29'd0, n};
        if (n != mwh_pkg::FULL_COUNT || last) begin
            h = acc_hash ^ acc_length;
            h = h ^ (h >> 16);
            h = h * mwh_pkg::FIN_C1;
            h = h ^ (h >> 13);
            h = h * mwh_pkg::FIN_C2;
            h = h ^ (h >> 16);
            expected_mem[exp_wr % EXP_DEPTH] = h;
            exp_wr++;
            msg_open = 1'b0;
        end
    endtask

    // Send one word; returns at the edge of its transfer with valid still high
    task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                             input logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_word <= word;
        i_valid_bytes <= count;
        i_last_word <= last;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        absorb_word(word, count, last);
        tx_count++;
    endtask

    // Drop valid and wait until the hasher has nothing left in flight
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        i_seed_we <= 1'b1;
        i_seed_data <= value;
        @(posedge i_clk);
        seed_copy = value;
        i_seed_we <= 1'b0;
    endtask

    // Field extremes, every count, short and empty messages, reset seed
    task automatic test_directed();
        send_word(32'h0000_0000, 3'd0, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b0);
        send_word(32'hffff_ffff, 3'd2, 1'b0);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h8000_0001, 3'd5, 1'b0);
        send_word(32'h7fff_fffe, 3'd6, 1'b0);
        send_word(32'h1234_5678, 3'd7, 1'b1);
        send_word(32'hdead_beef, 3'd4, 1'b0);
        send_word(32'h0000_0001, 3'd4, 1'b0);
        send_word(32'h00ab_cdef, 3'd3, 1'b1);
        send_word(32'h8000_0000, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'h5555_5555, 3'd4, 1'b0);
        send_word(32'haaaa_aaaa, 3'd2, 1'b0);
        wait_idle();
    endtask

    // Seed extremes, and a seed write inside an open message
    task automatic test_seed_change();
        write_seed(32'hffff_ffff);
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h0102_0304, 3'd4, 1'b0);
        send_word(32'h0506_0708, 3'd1, 1'b0);
        wait_idle();
        send_word(32'hcafe_f00d, 3'd4, 1'b0);
        wait_idle();
        // hold old seed for the open message, new one for the next
        write_seed(32'h8000_0000);
        send_word(32'h0bad_c0de, 3'd4, 1'b1);
        send_word(32'h0bad_c0de, 3'd4, 1'b1);
        wait_idle();
        write_seed(32'h0000_0000);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        wait_idle();
    endtask

    // Random messages: mostly full words, closed by a short or marked word
    task automatic send_random_message();
        int          nfull;
        logic [2:0]  cnt;
        logic [31:0] w;
        nfull = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        for (int k = 0; k < nfull; k++) begin
            w = $urandom;
            cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : mwh_pkg::FULL_COUNT;
            if ($urandom_range(0, 9) == 0) begin
                cnt = 3'($urandom_range(0, 7));
                send_word(w, cnt, 1'($urandom_range(0, 1)));
            end else begin
                send_word(w, cnt, 1'b0);
            end
        end
        w = $urandom;
        cnt = 3'($urandom_range(0, 4));
        if (cnt == mwh_pkg::FULL_COUNT) begin
            send_word(w, 3'($urandom_range(4, 7)), 1'b1);
        end else begin
            send_word(w, cnt, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random(input int n_items, input logic [31:0] seed);
        int start;
        write_seed(seed);
        start = tx_count;
        while (tx_count - start < n_items) begin
            send_random_message();
        end
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_seed_change();
        test_random(200, 32'h0000_0000);
        test_random(200, 32'hffff_ffff);
        test_random(200, $urandom);
        test_random(200, $urandom);
        test_random(200, $urandom);
        // finish with no input gaps and no output stalls
        quiet = 1'b1;
        test_random(200, $urandom);

        if (exp_wr != exp_rd) begin
            $error("hash_value: expected %h, actual none", expected_mem[exp_rd % EXP_DEPTH]);
            failures++;
        end
        if (failures == 0) begin
            $display("murmur3_word_hasher: match");
        end else begin
            $display("murmur3_word_hasher: mismatch");
        end
        $finish;
    end

endmodule

### files.f
sv/mwh_pkg.sv
sv/mwh_front.sv
sv/mwh_queue.sv
sv/mwh_back.sv
sv/murmur3_word_hasher.sv
sim/tb.sv
